// ===== hw/rtl/piecewise_linear_mapper_assert.svh =====
// ----------------------------------------------------------------------------
// piecewise linear mapper assertion macros
// shorthand for clocked implication checks used by the top level
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_MAPPER_ASSERT_SVH
`define PIECEWISE_LINEAR_MAPPER_ASSERT_SVH

// same-cycle implication
`define PLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg
// shared types, codes and saturation helper of the piecewise linear mapper
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_SYNTH = 2'd2;
    localparam logic [1:0] MODE_MAP   = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_ZERO_W = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] t_q16;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_ADD_RD  = 14'b00000000000010,
        ST_ADD_WR  = 14'b00000000000100,
        ST_ADD_PUT = 14'b00000000001000,
        ST_SYN_RD  = 14'b00000000010000,
        ST_SYN_LD  = 14'b00000000100000,
        ST_SYN_DIV = 14'b00000001000000,
        ST_SYN_MUL = 14'b00000010000000,
        ST_SYN_WR  = 14'b00000100000000,
        ST_MAP_RD  = 14'b00001000000000,
        ST_MAP_CMP = 14'b00010000000000,
        ST_MAP_SEG = 14'b00100000000000,
        ST_MAP_MUL = 14'b01000000000000,
        ST_MAP_OUT = 14'b10000000000000
    } t_state;

    function automatic t_q16 sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'(Q_MAX);
        lo = 64'(Q_MIN);
        if (v > hi) begin
            return Q_MAX;
        end else if (v < lo) begin
            return Q_MIN;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/plm_div.sv =====
// ----------------------------------------------------------------------------
// plm_div
// radix-2 restoring divider for segment slope, (dy * 2^16) / dx, truncated
// toward zero and saturated to signed 32 bits, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plm_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [plm_pkg::DATA_W:0]      i_dy,
    input  logic signed [plm_pkg::DATA_W:0]      i_dx,
    output logic                                 o_done,
    output plm_pkg::t_q16                        o_slope
);

    localparam int NUM_W = plm_pkg::DATA_W + plm_pkg::FRAC_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                              r_busy;
    logic [CNT_W-1:0]                  r_cnt;
    logic [plm_pkg::DATA_W-1:0]        r_rem;
    logic [NUM_W-1:0]                  r_quo;
    logic [plm_pkg::DATA_W-1:0]        r_den;
    logic                              r_neg;
    logic                              r_done;
    plm_pkg::t_q16                     r_slope;

    logic [plm_pkg::DATA_W:0]          dy_mag;
    logic [plm_pkg::DATA_W:0]          dx_mag;
    logic [plm_pkg::DATA_W:0]          trial;
    logic                              fits;
    logic signed [63:0]                q_signed;

    assign dy_mag   = i_dy[plm_pkg::DATA_W] ? -i_dy : i_dy;
    assign dx_mag   = i_dx[plm_pkg::DATA_W] ? -i_dx : i_dx;
    assign trial    = {r_rem, r_quo[NUM_W-1]};
    assign fits     = trial >= {1'b0, r_den};
    assign q_signed = r_neg ? -$signed({{(64-NUM_W){1'b0}}, r_quo})
                            :  $signed({{(64-NUM_W){1'b0}}, r_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {dy_mag[plm_pkg::DATA_W-1:0], {plm_pkg::FRAC_W{1'b0}}};
            r_den <= dx_mag[plm_pkg::DATA_W-1:0];
            r_neg <= i_dy[plm_pkg::DATA_W] ^ i_dx[plm_pkg::DATA_W];
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[plm_pkg::DATA_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
        if (r_busy && r_cnt == '0) begin
            r_slope <= plm_pkg::sat32(q_signed);
        end
    end

    assign o_done  = r_done;
    assign o_slope = r_slope;

endmodule

// ===== hw/rtl/piecewise_linear_mapper.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_mapper
// sorted anchor table with per-segment slope and intercept, signed Q16.16
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the o_ ports for one cycle with o_valid and cannot be stalled.
// Clear, a refused add, an add to an empty table, and map or synthesize on
// an empty table answer straight from idle. Add moves the anchors above the
// new one up one at a time, a read and a write each, through the anchor
// memory's one write port, and writes the new anchor after its last compare,
// or at once when it lands at the front. Map takes a read and a compare per
// binary search step (up to log2(MAX_POINTS)+1 steps), then the last range
// check, the segment read and the shared multiplier. Synthesize reads each
// anchor, gets its slope from the one-bit-per-cycle slope divider, then
// multiplies and writes the segment; a zero-width segment skips the divider.
// ----------------------------------------------------------------------------
`include "piecewise_linear_mapper_assert.svh"

module piecewise_linear_mapper #(
    parameter int MAX_POINTS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic signed [31:0]     i_x_value,
    input  logic signed [31:0]     i_y_value,
    output logic                   o_valid,
    output logic signed [31:0]     o_mapped_value,
    output logic [1:0]             o_status,
    output logic                   o_segments_current
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = plm_pkg::DATA_W;
    localparam int EW = 2 * DW;

    plm_pkg::t_state          r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_synth, n_synth;
    logic [CW-1:0]            r_j, n_j;
    logic [CW-1:0]            r_lo, n_lo;
    logic [CW-1:0]            r_hi, n_hi;
    plm_pkg::t_q16            r_x, n_x;
    plm_pkg::t_q16            r_y, n_y;
    plm_pkg::t_q16            r_x0, n_x0;
    plm_pkg::t_q16            r_y0, n_y0;
    plm_pkg::t_q16            r_x1, n_x1;
    plm_pkg::t_q16            r_y1, n_y1;
    plm_pkg::t_q16            r_k, n_k;
    plm_pkg::t_q16            r_b, n_b;
    logic [1:0]               r_status, n_status;
    logic signed [EW-1:0]     r_prod, n_prod;
    logic [MAX_POINTS-1:0]    r_seg_vld, n_seg_vld;
    logic                     r_o_valid, n_o_valid;
    plm_pkg::t_q16            r_o_value, n_o_value;
    logic [1:0]               r_o_status, n_o_status;
    logic                     r_o_cur, n_o_cur;

    logic [EW-1:0]            anc_mem [MAX_POINTS];
    logic                     anc_we;
    logic [AW-1:0]            anc_waddr;
    logic [EW-1:0]            anc_wdata;
    logic [AW-1:0]            anc_raddr;
    logic [EW-1:0]            r_anc_rd;

    logic [EW-1:0]            seg_mem [MAX_POINTS];
    logic                     seg_we;
    logic [AW-1:0]            seg_waddr;
    logic [EW-1:0]            seg_wdata;
    logic [AW-1:0]            seg_raddr;
    logic [EW-1:0]            r_seg_rd;
    logic                     r_seg_rd_vld;

    plm_pkg::t_q16            mul_a, mul_b;
    logic signed [EW-1:0]     mul_p;

    logic                     div_start;
    logic                     div_done;
    plm_pkg::t_q16            div_slope;
    logic signed [DW:0]       dx, dy;

    plm_pkg::t_q16            rd_x, rd_y;
    logic [CW-1:0]            j_dec;
    logic [CW-1:0]            j_inc;
    logic [CW-1:0]            mid;
    logic signed [EW-1:0]     icpt;

    assign rd_x  = r_anc_rd[EW-1:DW];
    assign rd_y  = r_anc_rd[DW-1:0];
    assign j_dec = r_j - CW'(1);
    assign j_inc = r_j + CW'(1);
    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign dx    = (DW + 1)'(rd_x) - (DW + 1)'(r_x0);
    assign dy    = (DW + 1)'(rd_y) - (DW + 1)'(r_y0);
    assign mul_p = mul_a * mul_b;
    assign icpt  = EW'(r_y1) - (r_prod >>> plm_pkg::FRAC_W);

    plm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dy    (dy),
        .i_dx    (dx),
        .o_done  (div_done),
        .o_slope (div_slope)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_synth    = r_synth;
        n_j        = r_j;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_x        = r_x;
        n_y        = r_y;
        n_x0       = r_x0;
        n_y0       = r_y0;
        n_x1       = r_x1;
        n_y1       = r_y1;
        n_k        = r_k;
        n_b        = r_b;
        n_status   = r_status;
        n_prod     = r_prod;
        n_seg_vld  = r_seg_vld;
        n_o_valid  = 1'b0;
        n_o_value  = r_o_value;
        n_o_status = r_o_status;
        n_o_cur    = r_o_cur;
        anc_we     = 1'b0;
        anc_waddr  = r_j[AW-1:0];
        anc_wdata  = {r_x, r_y};
        anc_raddr  = r_j[AW-1:0];
        seg_we     = 1'b0;
        seg_waddr  = r_j[AW-1:0];
        seg_wdata  = {r_k, icpt[DW-1:0]};
        seg_raddr  = r_j[AW-1:0];
        mul_a      = r_k;
        mul_b      = r_x1;
        div_start  = 1'b0;

        case (r_state)
            plm_pkg::ST_IDLE: begin
                if (start) begin
                    n_x        = i_x_value;
                    n_y        = i_y_value;
                    n_o_value  = '0;
                    n_o_status = plm_pkg::STAT_OK;
                    n_o_cur    = r_synth;
                    case (i_mode)
                        plm_pkg::MODE_CLEAR: begin
                            n_count   = '0;
                            n_synth   = 1'b0;
                            n_o_cur   = 1'b0;
                            n_o_valid = 1'b1;
                        end
                        plm_pkg::MODE_ADD: begin
                            if (r_count >= CW'(MAX_POINTS)) begin
                                n_o_status = plm_pkg::STAT_FULL;
                                n_o_valid  = 1'b1;
                            end else if (r_count == '0) begin
                                anc_we    = 1'b1;
                                anc_waddr = '0;
                                anc_wdata = {i_x_value, i_y_value};
                                n_count   = CW'(1);
                                n_synth   = 1'b0;
                                n_o_cur   = 1'b0;
                                n_o_valid = 1'b1;
                            end else begin
                                n_j     = r_count;
                                n_state = plm_pkg::ST_ADD_RD;
                            end
                        end
                        plm_pkg::MODE_SYNTH: begin
                            if (r_count == '0) begin
                                n_synth    = 1'b1;
                                n_o_cur    = 1'b1;
                                n_o_status = plm_pkg::STAT_EMPTY;
                                n_o_valid  = 1'b1;
                            end else begin
                                n_j      = '0;
                                n_x0     = '0;
                                n_y0     = '0;
                                n_status = plm_pkg::STAT_OK;
                                n_state  = plm_pkg::ST_SYN_RD;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_o_status = plm_pkg::STAT_EMPTY;
                                n_o_valid  = 1'b1;
                            end else begin
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_state = plm_pkg::ST_MAP_RD;
                            end
                        end
                    endcase
                end
            end
            plm_pkg::ST_ADD_RD: begin
                anc_raddr = j_dec[AW-1:0];
                n_state   = plm_pkg::ST_ADD_WR;
            end
            plm_pkg::ST_ADD_WR: begin
                anc_we = 1'b1;
                if (r_x < rd_x) begin
                    anc_wdata = r_anc_rd;
                    n_j       = j_dec;
                    n_state   = (j_dec == '0) ? plm_pkg::ST_ADD_PUT : plm_pkg::ST_ADD_RD;
                end else begin
                    n_count    = r_count + CW'(1);
                    n_synth    = 1'b0;
                    n_o_value  = '0;
                    n_o_status = plm_pkg::STAT_OK;
                    n_o_cur    = 1'b0;
                    n_o_valid  = 1'b1;
                    n_state    = plm_pkg::ST_IDLE;
                end
            end
            plm_pkg::ST_ADD_PUT: begin
                anc_we     = 1'b1;
                n_count    = r_count + CW'(1);
                n_synth    = 1'b0;
                n_o_value  = '0;
                n_o_status = plm_pkg::STAT_OK;
                n_o_cur    = 1'b0;
                n_o_valid  = 1'b1;
                n_state    = plm_pkg::ST_IDLE;
            end
            plm_pkg::ST_SYN_RD: begin
                n_state = plm_pkg::ST_SYN_LD;
            end
            plm_pkg::ST_SYN_LD: begin
                n_x1 = rd_x;
                n_y1 = rd_y;
                if (dx == '0) begin
                    n_k      = (dy > 0) ? plm_pkg::Q_MAX : ((dy < 0) ? plm_pkg::Q_MIN : '0);
                    n_status = plm_pkg::STAT_ZERO_W;
                    n_state  = plm_pkg::ST_SYN_MUL;
                end else begin
                    div_start = 1'b1;
                    n_state   = plm_pkg::ST_SYN_DIV;
                end
            end
            plm_pkg::ST_SYN_DIV: begin
                if (div_done) begin
                    n_k     = div_slope;
                    n_state = plm_pkg::ST_SYN_MUL;
                end
            end
            plm_pkg::ST_SYN_MUL: begin
                n_prod  = mul_p;
                n_state = plm_pkg::ST_SYN_WR;
            end
            plm_pkg::ST_SYN_WR: begin
                seg_we    = 1'b1;
                seg_wdata = {r_k, plm_pkg::sat32(icpt)};
                n_seg_vld[r_j[AW-1:0]] = 1'b1;
                n_x0 = r_x1;
                n_y0 = r_y1;
                n_j  = j_inc;
                if (j_inc == r_count) begin
                    n_synth    = 1'b1;
                    n_o_value  = '0;
                    n_o_status = r_status;
                    n_o_cur    = 1'b1;
                    n_o_valid  = 1'b1;
                    n_state    = plm_pkg::ST_IDLE;
                end else begin
                    n_state = plm_pkg::ST_SYN_RD;
                end
            end
            plm_pkg::ST_MAP_RD: begin
                if (r_lo < r_hi) begin
                    n_j       = mid;
                    anc_raddr = mid[AW-1:0];
                    n_state   = plm_pkg::ST_MAP_CMP;
                end else begin
                    n_j     = (r_hi >= r_count) ? (r_count - CW'(1)) : r_hi;
                    n_state = plm_pkg::ST_MAP_SEG;
                end
            end
            plm_pkg::ST_MAP_CMP: begin
                if (rd_x > r_x) begin
                    n_hi    = r_j;
                    n_state = plm_pkg::ST_MAP_RD;
                end else if (rd_x < r_x) begin
                    n_lo    = j_inc;
                    n_state = plm_pkg::ST_MAP_RD;
                end else begin
                    n_state = plm_pkg::ST_MAP_SEG;
                end
            end
            plm_pkg::ST_MAP_SEG: begin
                n_state = plm_pkg::ST_MAP_MUL;
            end
            plm_pkg::ST_MAP_MUL: begin
                mul_a   = r_seg_rd_vld ? r_seg_rd[EW-1:DW] : '0;
                mul_b   = r_x;
                n_b     = r_seg_rd_vld ? r_seg_rd[DW-1:0] : '0;
                n_prod  = mul_p;
                n_state = plm_pkg::ST_MAP_OUT;
            end
            plm_pkg::ST_MAP_OUT: begin
                n_o_value  = plm_pkg::sat32((r_prod >>> plm_pkg::FRAC_W) + EW'(r_b));
                n_o_status = plm_pkg::STAT_OK;
                n_o_cur    = r_synth;
                n_o_valid  = 1'b1;
                n_state    = plm_pkg::ST_IDLE;
            end
            default: begin
                n_state = plm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= plm_pkg::ST_IDLE;
            r_count   <= '0;
            r_synth   <= 1'b0;
            r_seg_vld <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_synth   <= n_synth;
            r_seg_vld <= n_seg_vld;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_x        <= n_x;
        r_y        <= n_y;
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_x1       <= n_x1;
        r_y1       <= n_y1;
        r_k        <= n_k;
        r_b        <= n_b;
        r_status   <= n_status;
        r_prod     <= n_prod;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
        r_o_cur    <= n_o_cur;
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            anc_mem[anc_waddr] <= anc_wdata;
        end
        r_anc_rd <= anc_mem[anc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            seg_mem[seg_waddr] <= seg_wdata;
        end
        r_seg_rd     <= seg_mem[seg_raddr];
        r_seg_rd_vld <= r_seg_vld[seg_raddr];
    end

    assign busy               = (r_state != plm_pkg::ST_IDLE);
    assign o_valid            = r_o_valid;
    assign o_mapped_value     = r_o_value;
    assign o_status           = r_o_status;
    assign o_segments_current = r_o_cur;

    `PLM_ASSERT_NOW(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    `PLM_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_valid, "item dropped")
    `PLM_ASSERT_NOW(a_full_zero, i_clk, i_rst_n, o_valid && o_status == plm_pkg::STAT_FULL, o_mapped_value == '0, "refused add with value")
    `PLM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_POINTS), "anchor count overflow")

endmodule
